@@ rtl/epsc_pkg.sv @@
// Shared types and constants of the encoder PID speed controller.
`timescale 1ns / 1ps
package epsc_pkg;

  localparam int unsigned StopHoldMs      = 100;
  localparam int unsigned DriveMaxDefault = 255;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 24;
  localparam int unsigned InTdataW  = 56;
  localparam int unsigned OutTdataW = 72;
  localparam int unsigned ProdW     = 52;
  localparam int unsigned AccW      = 53;
  localparam int unsigned ErrW      = 24;
  localparam int unsigned IntegW    = 40;

  typedef enum logic [2:0] {
    CFG_PERIOD = 3'd0,
    CFG_KP     = 3'd1,
    CFG_KI     = 3'd2,
    CFG_KD     = 3'd3,
    CFG_SCALE  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_EDGE = 2'd0,
    MODE_MOVE = 2'd1,
    MODE_STOP = 2'd2,
    MODE_NOP  = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE, S_EDGE, S_STOP, S_MOVE, S_SPEED, S_ERR, S_INT, S_INTACC,
    S_PACC, S_IACC, S_DSUB, S_ABS, S_CLAMP, S_FINISH, S_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_EDGE, OP_STOP, OP_MOVE, OP_SPEED, OP_ERR, OP_INT,
    OP_INTACC, OP_PACC, OP_IACC, OP_DSUB, OP_ABS, OP_CLAMP, OP_FINISH, OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic upd;
    logic err_zero;
  } dp_stat_t;

endpackage

@@ rtl/encoder_pid_speed_controller.sv @@
// Top level of the encoder PID speed controller.
//
//  channel   direction  tdata / tuser                                   handshake
//  s_axis    in         mode; enc_a, enc_b, now_ms, target_speed, fwd   tvalid/tready
//  m_axis    out        drive, dir pins, position, error; sample_done   tvalid/tready
//  cfg       in         register index, write data                      cfg_we_i
//
// One request at a time. Encoder edge, stop and idle requests and a move request
// without an update go on to the output step; a move that runs the control update
// steps through the single shared 17x35 multiplier and the accumulator, and skips the
// gain steps when the error is zero. Reset clears all loop state at once.
// A result waiting in the output register does not block the next request; a second
// finished result waits until the first is taken.
`timescale 1ns / 1ps
module encoder_pid_speed_controller #(
  parameter int unsigned DRIVE_MAX = epsc_pkg::DriveMaxDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [0] enc_a, [1] enc_b, [33:2] now_ms, [49:34] target_speed, [50] forward
  input  logic [epsc_pkg::InTdataW-1:0]   s_axis_tdata_i,
  // [1:0] mode
  input  logic [1:0]                      s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [7:0] drive_level, [8] dir_pin_one, [9] dir_pin_two, [41:10] position_count,
  // [65:42] speed_error
  output logic [epsc_pkg::OutTdataW-1:0]  m_axis_tdata_o,
  // [0] sample_done
  output logic                            m_axis_tuser_o,
  input  logic                            cfg_we_i,
  input  logic [epsc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [epsc_pkg::CfgDataW-1:0]   cfg_data_i
);
  import epsc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  epsc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .mode_i    (s_axis_tuser_i),
    .m_ready_i (m_axis_tready_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .cmd_o     (cmd),
    .stat_i    (stat)
  );

  epsc_dp #(
    .DRIVE_MAX (DRIVE_MAX)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (m_axis_tdata_o),
    .out_done_o (m_axis_tuser_o)
  );

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request accepted while another is in progress");

  a_drive_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> 32'(m_axis_tdata_o[7:0]) <= DRIVE_MAX)
    else $error("drive level above limit");

  a_update_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[8] != m_axis_tdata_o[9])
    else $error("control update without a direction set");

endmodule

@@ rtl/epsc_ctrl.sv @@
// Sequencer of the encoder PID speed controller.
`timescale 1ns / 1ps
module epsc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  input  logic [1:0]        mode_i,
  input  logic              m_ready_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  output epsc_pkg::dp_cmd_t cmd_o,
  input  epsc_pkg::dp_stat_t stat_i
);
  import epsc_pkg::*;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   out_free;
  mode_e  mode;

  assign mode     = mode_e'(mode_i);
  assign out_free = !out_vld_q || m_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          case (mode)
            MODE_EDGE: state_d = S_EDGE;
            MODE_MOVE: state_d = S_MOVE;
            MODE_STOP: state_d = S_STOP;
            default:   state_d = S_OUT;
          endcase
        end
      end
      S_EDGE:   state_d = S_OUT;
      S_STOP:   state_d = S_OUT;
      S_MOVE:   state_d = stat_i.upd ? S_SPEED : S_OUT;
      S_SPEED:  state_d = S_ERR;
      S_ERR:    state_d = S_INT;
      S_INT:    state_d = stat_i.err_zero ? S_FINISH : S_INTACC;
      S_INTACC: state_d = S_PACC;
      S_PACC:   state_d = S_IACC;
      S_IACC:   state_d = S_DSUB;
      S_DSUB:   state_d = S_ABS;
      S_ABS:    state_d = S_CLAMP;
      S_CLAMP:  state_d = S_FINISH;
      S_FINISH: state_d = S_OUT;
      S_OUT: begin
        if (out_free) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_ready_o = 1'b0;
    cmd_o.op  = OP_NONE;
    case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) cmd_o.op = OP_LOAD;
      end
      S_EDGE:   cmd_o.op = OP_EDGE;
      S_STOP:   cmd_o.op = OP_STOP;
      S_MOVE:   cmd_o.op = OP_MOVE;
      S_SPEED:  cmd_o.op = OP_SPEED;
      S_ERR:    cmd_o.op = OP_ERR;
      S_INT:    cmd_o.op = OP_INT;
      S_INTACC: cmd_o.op = OP_INTACC;
      S_PACC:   cmd_o.op = OP_PACC;
      S_IACC:   cmd_o.op = OP_IACC;
      S_DSUB:   cmd_o.op = OP_DSUB;
      S_ABS:    cmd_o.op = OP_ABS;
      S_CLAMP:  cmd_o.op = OP_CLAMP;
      S_FINISH: cmd_o.op = OP_FINISH;
      S_OUT: begin
        if (out_free) cmd_o.op = OP_OUT;
      end
      default:  cmd_o.op = OP_NONE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (state_q == S_OUT && out_free) begin
      out_vld_d = 1'b1;
    end else if (m_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  assign m_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

@@ rtl/epsc_dp.sv @@
// Datapath of the encoder PID speed controller: state, shared multiplier, result register.
`timescale 1ns / 1ps
module epsc_dp #(
  parameter int unsigned DRIVE_MAX = epsc_pkg::DriveMaxDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [epsc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [epsc_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic [epsc_pkg::InTdataW-1:0]   in_data_i,
  input  epsc_pkg::dp_cmd_t               cmd_i,
  output epsc_pkg::dp_stat_t              stat_o,
  output logic [epsc_pkg::OutTdataW-1:0]  out_data_o,
  output logic                            out_done_o
);
  import epsc_pkg::*;

  localparam int unsigned DriveW = $clog2(DRIVE_MAX + 1) + 8;
  localparam logic [AccW-1:0] DriveMaxQ = AccW'(DRIVE_MAX) << 8;
  localparam logic signed [43:0] ErrMaxW = 44'sd8388607;
  localparam logic signed [43:0] ErrMinW = -44'sd8388608;

  // configuration
  logic [9:0]  period_q;
  logic [15:0] kp_q, ki_q, kd_q;
  logic [23:0] scale_q;

  // latched request
  logic        enc_a_q, enc_b_q, fwd_q;
  logic [31:0] now_q;
  logic [15:0] target_q;

  // controller state
  logic [31:0]        pos_q, pos_d, prev_pos_q, prev_pos_d, prev_speed_q, prev_speed_d;
  logic [IntegW-1:0]  integ_q, integ_d;
  logic [DriveW-1:0]  drive_q, drive_d;
  logic [31:0]        last_upd_q, last_upd_d, stop_pos_q, stop_pos_d, stop_time_q, stop_time_d;
  logic               dir_latch_q, dir_latch_d, stop_lat_q, stop_lat_d;
  logic [ErrW-1:0]    last_err_q, last_err_d;
  logic [1:0]         dir_q, dir_d;
  logic               done_q, done_d;

  // working registers
  logic [32:0]        diff_q, diff_d, speed_q, speed_d;
  logic [ProdW-1:0]   prod_q, prod_d;
  logic [34:0]        dspeed_q, dspeed_d;
  logic [AccW-1:0]    acc_q, acc_d;

  // result register
  logic [OutTdataW-1:0] out_data_q;
  logic                 out_done_q;

  // shared multiplier
  logic signed [16:0]      mul_a;
  logic signed [34:0]      mul_b;
  logic signed [ProdW-1:0] mul_p;

  logic               restart;
  logic [31:0]        eff_prev, eff_last, elapsed, stop_pos_eff, stop_time_eff;
  logic               stop_ge, stop_lat_new;
  logic signed [43:0] err_w;
  logic [ErrW-1:0]    err_sat;
  logic signed [40:0] integ_sum;
  logic [DriveW-1:0]  lvl_w;
  logic [7:0]         level;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_SPEED: begin
        mul_a = {target_q[15], target_q};
        mul_b = {11'b0, scale_q};
      end
      OP_INT: begin
        mul_a = {1'b0, ki_q};
        mul_b = {{11{last_err_q[ErrW-1]}}, last_err_q};
      end
      OP_INTACC: begin
        mul_a = {1'b0, kp_q};
        mul_b = {{11{last_err_q[ErrW-1]}}, last_err_q};
      end
      OP_PACC: begin
        mul_a = {1'b0, kd_q};
        mul_b = dspeed_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign restart  = fwd_q != dir_latch_q;
  assign eff_prev = restart ? pos_q : prev_pos_q;
  assign eff_last = restart ? now_q : last_upd_q;
  assign elapsed  = now_q - eff_last;

  assign stop_pos_eff  = stop_lat_q ? stop_pos_q : pos_q;
  assign stop_time_eff = stop_lat_q ? stop_time_q : now_q;
  assign stop_ge       = $signed(pos_q) >= $signed(stop_pos_eff);
  assign stop_lat_new  = stop_lat_q || stop_ge;

  assign err_w = $signed(prod_q[51:8]) - $signed({3'b0, speed_q, 8'b0});
  always_comb begin
    if (err_w > ErrMaxW) begin
      err_sat = 24'h7FFFFF;
    end else if (err_w < ErrMinW) begin
      err_sat = 24'h800000;
    end else begin
      err_sat = err_w[ErrW-1:0];
    end
  end

  assign integ_sum = $signed(prod_q[48:8]) + $signed({integ_q[IntegW-1], integ_q});

  always_comb begin
    pos_d        = pos_q;
    prev_pos_d   = prev_pos_q;
    prev_speed_d = prev_speed_q;
    integ_d      = integ_q;
    drive_d      = drive_q;
    last_upd_d   = last_upd_q;
    stop_pos_d   = stop_pos_q;
    stop_time_d  = stop_time_q;
    dir_latch_d  = dir_latch_q;
    stop_lat_d   = stop_lat_q;
    last_err_d   = last_err_q;
    dir_d        = dir_q;
    done_d       = done_q;
    diff_d       = diff_q;
    speed_d      = speed_q;
    prod_d       = prod_q;
    dspeed_d     = dspeed_q;
    acc_d        = acc_q;
    case (cmd_i.op)
      OP_LOAD: done_d = 1'b0;
      OP_EDGE: pos_d = (enc_a_q != enc_b_q) ? pos_q + 32'd1 : pos_q - 32'd1;
      OP_STOP: begin
        if (!stop_lat_q) begin
          stop_pos_d  = pos_q;
          stop_time_d = now_q;
        end
        stop_lat_d = stop_lat_new;
        dir_d      = stop_ge ? 2'b01 : 2'b10;
        if (stop_lat_new && (now_q - stop_time_eff) > 32'(StopHoldMs)) drive_d = '0;
      end
      OP_MOVE: begin
        if (restart) begin
          prev_pos_d   = pos_q;
          last_upd_d   = now_q;
          drive_d      = '0;
          integ_d      = '0;
          prev_speed_d = '0;
          dir_latch_d  = ~dir_latch_q;
        end
        dir_d  = fwd_q ? 2'b10 : 2'b01;
        diff_d = {pos_q[31], pos_q} - {eff_prev[31], eff_prev};
      end
      OP_SPEED: begin
        speed_d = diff_q[32] ? -diff_q : diff_q;
        prod_d  = mul_p;
      end
      OP_ERR: last_err_d = err_sat;
      OP_INT: begin
        prod_d   = mul_p;
        dspeed_d = {2'b0, speed_q} - {3'b0, prev_speed_q};
      end
      OP_INTACC: begin
        if (integ_sum[40] != integ_sum[39]) begin
          integ_d = integ_sum[40] ? {1'b1, {(IntegW-1){1'b0}}} : {1'b0, {(IntegW-1){1'b1}}};
        end else begin
          integ_d = integ_sum[IntegW-1:0];
        end
        prod_d = mul_p;
        acc_d  = {{(AccW-DriveW){1'b0}}, drive_q};
      end
      OP_PACC: begin
        acc_d  = acc_q + {{(AccW-44){prod_q[ProdW-1]}}, prod_q[51:8]};
        prod_d = mul_p;
      end
      OP_IACC:  acc_d = acc_q + {{(AccW-IntegW){integ_q[IntegW-1]}}, integ_q};
      OP_DSUB:  acc_d = acc_q - {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
      OP_ABS:   acc_d = acc_q[AccW-1] ? -acc_q : acc_q;
      OP_CLAMP: drive_d = (acc_q > DriveMaxQ) ? DriveMaxQ[DriveW-1:0] : acc_q[DriveW-1:0];
      OP_FINISH: begin
        prev_speed_d = speed_q[31:0];
        last_upd_d   = now_q;
        prev_pos_d   = pos_q;
        done_d       = 1'b1;
      end
      default: done_d = done_q;
    endcase
  end

  assign lvl_w = drive_q >> 8;
  assign level = (lvl_w > DriveW'(255)) ? 8'hFF : lvl_w[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= 10'd10;
      kp_q     <= '0;
      ki_q     <= '0;
      kd_q     <= '0;
      scale_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PERIOD: period_q <= cfg_data_i[9:0];
        CFG_KP:     kp_q     <= cfg_data_i[15:0];
        CFG_KI:     ki_q     <= cfg_data_i[15:0];
        CFG_KD:     kd_q     <= cfg_data_i[15:0];
        CFG_SCALE:  scale_q  <= cfg_data_i[23:0];
        default:    period_q <= period_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      prev_pos_q   <= '0;
      prev_speed_q <= '0;
      integ_q      <= '0;
      drive_q      <= '0;
      last_upd_q   <= '0;
      stop_pos_q   <= '0;
      stop_time_q  <= '0;
      dir_latch_q  <= 1'b0;
      stop_lat_q   <= 1'b0;
      last_err_q   <= '0;
      dir_q        <= '0;
      done_q       <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      prev_pos_q   <= prev_pos_d;
      prev_speed_q <= prev_speed_d;
      integ_q      <= integ_d;
      drive_q      <= drive_d;
      last_upd_q   <= last_upd_d;
      stop_pos_q   <= stop_pos_d;
      stop_time_q  <= stop_time_d;
      dir_latch_q  <= dir_latch_d;
      stop_lat_q   <= stop_lat_d;
      last_err_q   <= last_err_d;
      dir_q        <= dir_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q   <= diff_d;
    speed_q  <= speed_d;
    prod_q   <= prod_d;
    dspeed_q <= dspeed_d;
    acc_q    <= acc_d;
    if (cmd_i.op == OP_LOAD) begin
      enc_a_q  <= in_data_i[0];
      enc_b_q  <= in_data_i[1];
      now_q    <= in_data_i[33:2];
      target_q <= in_data_i[49:34];
      fwd_q    <= in_data_i[50];
    end
    if (cmd_i.op == OP_OUT) begin
      out_data_q <= {6'b0, last_err_q, pos_q, dir_q, level};
      out_done_q <= done_q;
    end
  end

  // update decision for the move request being sequenced, after any restart
  assign stat_o.upd      = elapsed >= {22'b0, period_q};
  assign stat_o.err_zero = last_err_q == '0;
  assign out_data_o      = out_data_q;
  assign out_done_o      = out_done_q;

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the encoder PID speed controller: random traffic vs a local predictor.
`timescale 1ns / 1ps
module testbench;
  import epsc_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam longint IntegMax = 64'sd549755813887;
  localparam longint IntegMin = -64'sd549755813888;
  localparam longint ErrMax   = 64'sd8388607;
  localparam longint ErrMin   = -64'sd8388608;
  localparam longint DriveCap = longint'(DriveMaxDefault) * 256;

  typedef struct {
    mode_e            mode;
    bit               enc_a;
    bit               enc_b;
    bit [31:0]        now_ms;
    bit signed [15:0] target;
    bit               fwd;
  } motor_req_t;

  typedef struct {
    bit [7:0]         drive;
    bit               pin_one;
    bit               pin_two;
    bit signed [31:0] position;
    bit signed [23:0] speed_err;
    bit               sample_done;
  } motor_status_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_valid = 1'b0;
  logic                 s_ready;
  logic [InTdataW-1:0]  s_tdata = '0;
  logic [1:0]           s_tuser = '0;
  logic                 m_valid;
  logic                 m_ready = 1'b0;
  logic [OutTdataW-1:0] m_tdata;
  logic                 m_tuser;
  logic                 cfg_we = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;

  encoder_pid_speed_controller u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // controller registers and loop state as the predictor sees them
  bit [9:0]  period_ms = 10'd10;
  bit [15:0] kp_gain, ki_gain, kd_gain;
  bit [23:0] speed_scale;
  bit [31:0] pos, prev_pos, prev_speed, last_upd_ms, stop_pos, stop_ms;
  longint    integ_sum, drive_acc;
  bit        heading_fwd, stop_held;
  bit signed [23:0] last_err;
  bit [1:0]  dir_pins;

  motor_req_t    req_backlog[$];
  motor_status_t status_due[$];
  motor_req_t    cur_req;
  int unsigned   reqs_accepted, reqs_retired, res_seen, res_handled;
  int unsigned   cycle_cnt, fail_cnt;
  int            send_wait, recv_wait, send_burst, recv_burst;
  bit [31:0]     gen_ms;
  bit            gen_fwd;

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic motor_status_t controller_step(motor_req_t r);
    motor_status_t s;
    longint diff, speed, want, err, dspeed;
    bit [31:0] elapsed;
    s.sample_done = 1'b0;
    case (r.mode)
      MODE_EDGE: begin
        pos = (r.enc_a != r.enc_b) ? pos + 32'd1 : pos - 32'd1;
      end
      MODE_MOVE: begin
        if (r.fwd != heading_fwd) begin
          prev_pos    = pos;
          last_upd_ms = r.now_ms;
          drive_acc   = 0;
          integ_sum   = 0;
          prev_speed  = '0;
          heading_fwd = r.fwd;
        end
        dir_pins = r.fwd ? 2'b10 : 2'b01;
        elapsed  = r.now_ms - last_upd_ms;
        if (elapsed >= {22'd0, period_ms}) begin
          diff  = longint'($signed(pos)) - longint'($signed(prev_pos));
          speed = (diff < 0) ? -diff : diff;
          want  = (longint'(r.target) * longint'(speed_scale)) >>> 8;
          err   = clamp_to(want - speed * 256, ErrMin, ErrMax);
          last_err = err[23:0];
          if (err != 0) begin
            dspeed    = speed - longint'(prev_speed);
            integ_sum = clamp_to(integ_sum + ((longint'(ki_gain) * err) >>> 8),
                                 IntegMin, IntegMax);
            drive_acc = drive_acc + ((longint'(kp_gain) * err) >>> 8) + integ_sum
                        - longint'(kd_gain) * dspeed;
            if (drive_acc < 0) drive_acc = -drive_acc;
          end
          if (drive_acc > DriveCap) drive_acc = DriveCap;
          prev_speed    = speed[31:0];
          last_upd_ms   = r.now_ms;
          prev_pos      = pos;
          s.sample_done = 1'b1;
        end
      end
      MODE_STOP: begin
        if (!stop_held) begin
          stop_pos = pos;
          stop_ms  = r.now_ms;
        end
        if ($signed(pos) >= $signed(stop_pos)) begin
          stop_held = 1'b1;
          dir_pins  = 2'b01;
        end else begin
          dir_pins = 2'b10;
        end
        elapsed = r.now_ms - stop_ms;
        if (stop_held && elapsed > StopHoldMs) drive_acc = 0;
      end
      default: ;
    endcase
    s.drive     = ((drive_acc >>> 8) > 255) ? 8'd255 : drive_acc[15:8];
    s.pin_one   = dir_pins[0];
    s.pin_two   = dir_pins[1];
    s.position  = pos;
    s.speed_err = last_err;
    return s;
  endfunction

  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) burst = $urandom_range(10, 30);
    return $urandom_range(0, 18);
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // request side
  always @(negedge clk_i) begin : drive_requests
    bit nxt;
    nxt = s_valid;
    if (rst_ni) begin
      if (s_valid && reqs_accepted != reqs_retired) begin
        reqs_retired++;
        nxt = 1'b0;
        send_wait = draw_wait(send_burst);
      end
      if (!nxt) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (req_backlog.size() > 0) begin
          cur_req = req_backlog.pop_front();
          nxt = 1'b1;
        end
      end
    end
    s_valid <= nxt;
    s_tdata <= InTdataW'({cur_req.fwd, cur_req.target, cur_req.now_ms,
                          cur_req.enc_b, cur_req.enc_a});
    s_tuser <= cur_req.mode;
  end

  // result side back-pressure
  always @(negedge clk_i) begin : pace_results
    if (res_seen != res_handled) begin
      res_handled++;
      recv_wait = draw_wait(recv_burst);
    end
    if (recv_wait > 0) begin
      recv_wait--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_results
    motor_status_t got, want;
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      if (rst_ni && s_valid && s_ready) begin
        status_due.push_back(controller_step(cur_req));
        reqs_accepted++;
      end
      if (rst_ni && m_valid && m_ready) begin
        res_seen++;
        got.drive       = m_tdata[7:0];
        got.pin_one     = m_tdata[8];
        got.pin_two     = m_tdata[9];
        got.position    = m_tdata[41:10];
        got.speed_err   = m_tdata[65:42];
        got.sample_done = m_tuser;
        if (status_due.size() == 0) begin
          $error("result with no request outstanding");
          fail_cnt++;
        end else begin
          want = status_due.pop_front();
          check_field("drive_level", want.drive, got.drive);
          check_field("dir_pin_one", want.pin_one, got.pin_one);
          check_field("dir_pin_two", want.pin_two, got.pin_two);
          check_field("position_count", want.position, got.position);
          check_field("speed_error", want.speed_err, got.speed_err);
          check_field("sample_done", want.sample_done, got.sample_done);
        end
      end
    end
  end

  task automatic wait_idle();
    while (req_backlog.size() != 0 || s_valid || status_due.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, bit [23:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      CFG_PERIOD: period_ms   = val[9:0];
      CFG_KP:     kp_gain     = val[15:0];
      CFG_KI:     ki_gain     = val[15:0];
      CFG_KD:     kd_gain     = val[15:0];
      CFG_SCALE:  speed_scale = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_loop(bit [9:0] per, bit [15:0] kp, bit [15:0] ki, bit [15:0] kd,
                          bit [23:0] scale);
    wait_idle();
    write_reg(CFG_PERIOD, {14'd0, per});
    write_reg(CFG_KP, {8'd0, kp});
    write_reg(CFG_KI, {8'd0, ki});
    write_reg(CFG_KD, {8'd0, kd});
    write_reg(CFG_SCALE, scale);
  endtask

  function automatic motor_req_t rand_req();
    motor_req_t r;
    r.mode   = mode_e'($urandom_range(0, 3));
    r.enc_a  = $urandom_range(0, 1);
    r.enc_b  = $urandom_range(0, 1);
    r.now_ms = $urandom();
    r.target = 16'($urandom());
    r.fwd    = $urandom_range(0, 1);
    return r;
  endfunction

  task automatic queue_req(mode_e m, bit a, bit b, bit [31:0] now, bit [15:0] tgt, bit fwd);
    motor_req_t r;
    r = rand_req();
    r.mode = m;
    if (m == MODE_EDGE) begin
      r.enc_a = a;
      r.enc_b = b;
    end
    if (m == MODE_MOVE || m == MODE_STOP) r.now_ms = now;
    if (m == MODE_MOVE) begin
      r.target = tgt;
      r.fwd    = fwd;
    end
    req_backlog.push_back(r);
  endtask

  function automatic bit [15:0] pick_target();
    bit [15:0] t;
    if ($urandom_range(0, 4) == 0) return 16'($urandom());
    t = 16'($urandom_range(0, 2048));
    if ($urandom_range(0, 1) != 0) t = -t;
    return t;
  endfunction

  // mostly well-formed edge/move/stop/idle traffic with a few wild timestamps
  task automatic gen_traffic(int count, int unsigned step_max, int unsigned up_pct);
    motor_req_t r;
    int unsigned pick;
    for (int i = 0; i < count; i++) begin
      r = rand_req();
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        r.mode  = MODE_EDGE;
        r.enc_b = ($urandom_range(0, 99) < up_pct) ? ~r.enc_a : r.enc_a;
      end else if (pick < 80) begin
        r.mode = MODE_MOVE;
        gen_ms += $urandom_range(0, step_max);
        r.now_ms = gen_ms;
        if ($urandom_range(0, 9) == 0) gen_fwd = ~gen_fwd;
        r.fwd    = gen_fwd;
        r.target = pick_target();
      end else if (pick < 88) begin
        r.mode = MODE_STOP;
        gen_ms += $urandom_range(0, step_max);
        r.now_ms = gen_ms;
      end else if (pick < 92) begin
        r.mode = MODE_NOP;
      end else begin
        r.mode = MODE_MOVE;
      end
      req_backlog.push_back(r);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_loop(10'd10, 16'h0100, 16'h0040, 16'h0020, 24'h000400);
    queue_req(MODE_NOP, 1'b0, 1'b0, '0, '0, 1'b0);
    queue_req(MODE_EDGE, 1'b1, 1'b0, '0, '0, 1'b0);
    queue_req(MODE_EDGE, 1'b0, 1'b1, '0, '0, 1'b0);
    queue_req(MODE_EDGE, 1'b1, 1'b1, '0, '0, 1'b0);
    queue_req(MODE_EDGE, 1'b0, 1'b0, '0, '0, 1'b0);
    // turn to forward: loop restarts, no update yet
    queue_req(MODE_MOVE, 1'b0, 1'b0, 32'd5, 16'h0100, 1'b1);
    repeat (4) queue_req(MODE_EDGE, 1'b1, 1'b0, '0, '0, 1'b0);
    queue_req(MODE_MOVE, 1'b0, 1'b0, 32'd15, 16'h0200, 1'b1);
    queue_req(MODE_MOVE, 1'b0, 1'b0, 32'd16, 16'h7FFF, 1'b1);
    queue_req(MODE_MOVE, 1'b0, 1'b0, 32'd30, 16'h7FFF, 1'b1);
    queue_req(MODE_MOVE, 1'b0, 1'b0, 32'd40, 16'h8000, 1'b1);
    // back to reverse, then an update with zero error
    queue_req(MODE_MOVE, 1'b0, 1'b0, 32'd41, 16'h0000, 1'b0);
    queue_req(MODE_MOVE, 1'b0, 1'b0, 32'd60, 16'h0000, 1'b0);
    queue_req(MODE_EDGE, 1'b0, 1'b0, '0, '0, 1'b0);
    // stop latches here; hold time boundary checked either side
    queue_req(MODE_STOP, 1'b0, 1'b0, 32'd100, '0, 1'b0);
    queue_req(MODE_EDGE, 1'b0, 1'b0, '0, '0, 1'b0);
    queue_req(MODE_STOP, 1'b0, 1'b0, 32'd150, '0, 1'b0);
    queue_req(MODE_STOP, 1'b0, 1'b0, 32'd200, '0, 1'b0);
    queue_req(MODE_STOP, 1'b0, 1'b0, 32'd201, '0, 1'b0);
    queue_req(MODE_EDGE, 1'b1, 1'b0, '0, '0, 1'b0);
    queue_req(MODE_EDGE, 1'b0, 1'b1, '0, '0, 1'b0);
    queue_req(MODE_STOP, 1'b0, 1'b0, 32'hFFFF_FFFF, '0, 1'b0);

    gen_ms  = 32'd300;
    gen_fwd = 1'b1;
    set_loop(10'($urandom_range(1, 20)), 16'($urandom_range(0, 512)),
             16'($urandom_range(0, 512)), 16'($urandom_range(0, 512)),
             24'($urandom_range(0, 4096)));
    gen_traffic(60, 30, 70);

    // zero period: every move updates
    set_loop(10'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
    gen_traffic(50, 3, 50);

    // drive the integral into saturation
    set_loop(10'd1, 16'h0000, 16'hFFFF, 16'h0000, 24'hFFFFFF);
    gen_fwd = 1'b1;
    // reverse then forward: the loop restarts from a clear integral either way
    gen_ms += 1;
    queue_req(MODE_MOVE, 1'b0, 1'b0, gen_ms, 16'h7FFF, 1'b0);
    for (int i = 0; i < 280; i++) begin
      if (i % 28 == 27) begin
        queue_req(MODE_EDGE, 1'b1, 1'b0, '0, '0, 1'b0);
      end else begin
        gen_ms += 1;
        queue_req(MODE_MOVE, 1'b0, 1'b0, gen_ms, 16'h7FFF, 1'b1);
      end
    end

    set_loop(10'd1000, 16'($urandom()), 16'($urandom()), 16'($urandom()),
             24'($urandom()));
    gen_traffic(70, 1500, 60);

    // timestamps run through the 32-bit wrap
    gen_ms = 32'hFFFF_F000;
    set_loop(10'($urandom_range(0, 1023)), 16'($urandom_range(0, 1024)),
             16'($urandom_range(0, 256)), 16'($urandom()), 24'($urandom()));
    gen_traffic(60, 2 * period_ms + 2, 40);
    set_loop(10'd1023, 16'($urandom()), 16'($urandom()), 16'($urandom_range(0, 64)),
             24'($urandom_range(0, 65535)));
    gen_traffic(60, 2100, 55);

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0 && status_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
